FILE: rtl/scu_pkg.sv
// ============================================================================
// scu_pkg
// Shared constants and types of the sector cache tag / LRU / dirty controller.
// ============================================================================
`default_nettype none

package scu_pkg;

    // Default geometry
    localparam int CACHE_SLOTS_DEF = 64;
    localparam int SECTOR_BITS_DEF = 32;

    // Fixed port widths
    localparam int CMD_W    = 2;
    localparam int ACT_W    = 2;
    localparam int SLOT_W   = 6;
    localparam int SECTOR_W = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    // Result action codes
    localparam logic [ACT_W-1:0] ACT_GRANT     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITEBACK = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FILL      = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_DECIDE,
        ST_WB_EMIT,
        ST_FILL,
        ST_GRANT,
        ST_TICK_SCAN,
        ST_TICK_EMIT
    } state_t;

    // Control of the tag scan unit
    typedef struct packed {
        logic clear;   // start of a new pass, drop earlier finds
        logic issue;   // a tag read is issued this cycle
    } scan_ctl_t;

    // Flags reported by the tag scan unit
    typedef struct packed {
        logic match_found;
        logic free_found;
    } scan_res_t;

endpackage

`default_nettype wire

FILE: rtl/scu_tag_ram.sv
// ============================================================================
// scu_tag_ram
// Single write port, single read port tag store with registered read data.
// ============================================================================
`default_nettype none

module scu_tag_ram #(
    parameter int DEPTH = scu_pkg::CACHE_SLOTS_DEF,
    parameter int WIDTH = scu_pkg::SECTOR_BITS_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/scu_recency.sv
// ============================================================================
// scu_recency
// Recency rank of each slot (0 = most recent) with registered promotion.
// ============================================================================
`default_nettype none

module scu_recency #(
    parameter int CACHE_SLOTS = scu_pkg::CACHE_SLOTS_DEF,
    localparam int IDX_W      = $clog2(CACHE_SLOTS)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             promote_en,
    input  wire logic [IDX_W-1:0] promote_slot,
    input  wire logic [IDX_W-1:0] promote_old,
    input  wire logic [IDX_W-1:0] rd_idx,
    output logic      [IDX_W-1:0] rd_rank,
    output logic                  rd_lru
);

    localparam logic [IDX_W-1:0] LAST_RANK = IDX_W'(CACHE_SLOTS - 1);

    logic [IDX_W-1:0] rank_reg  [CACHE_SLOTS];
    logic [IDX_W-1:0] rank_next [CACHE_SLOTS];

    // Promotion: ranks younger than the promoted slot age by one
    always_comb
    begin
        for (int i = 0; i < CACHE_SLOTS; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (promote_en)
            begin
                if (promote_slot == IDX_W'(i))
                begin
                    rank_next[i] = '0;
                end
                else if (rank_reg[i] < promote_old)
                begin
                    rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
            end
        end
    end

    // Rank lanes, reset to slot order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CACHE_SLOTS; i++)
            begin
                rank_reg[i] <= IDX_W'(i);
            end
        end
        else
        begin
            rank_reg <= rank_next;
        end
    end

    // Readout for the scan unit
    assign rd_rank = rank_reg[rd_idx];
    assign rd_lru  = (rank_reg[rd_idx] == LAST_RANK);

endmodule

`default_nettype wire

FILE: rtl/scu_scan.sv
// ============================================================================
// scu_scan
// Shared compare unit: walks the tag store one slot per cycle and records the
// first matching slot, the first free slot and the least recent slot.
// ============================================================================
`default_nettype none

module scu_scan #(
    parameter int CACHE_SLOTS = scu_pkg::CACHE_SLOTS_DEF,
    parameter int SECTOR_BITS = scu_pkg::SECTOR_BITS_DEF,
    localparam int IDX_W      = $clog2(CACHE_SLOTS)
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire scu_pkg::scan_ctl_t     ctl,
    input  wire logic [IDX_W-1:0]       issue_idx,
    input  wire logic [SECTOR_BITS-1:0] key,
    input  wire logic [SECTOR_BITS-1:0] tag_rd,
    input  wire logic [CACHE_SLOTS-1:0] occupied,
    input  wire logic [IDX_W-1:0]       cmp_rank,
    input  wire logic                   cmp_lru,
    output logic      [IDX_W-1:0]       cmp_idx,
    output scu_pkg::scan_res_t          res,
    output logic      [IDX_W-1:0]       match_idx,
    output logic      [IDX_W-1:0]       match_rank,
    output logic      [IDX_W-1:0]       free_idx,
    output logic      [IDX_W-1:0]       free_rank,
    output logic      [IDX_W-1:0]       lru_idx
);

    logic             cmp_valid_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             match_found_reg;
    logic             free_found_reg;
    logic             lru_found_reg;
    logic [IDX_W-1:0] match_idx_reg;
    logic [IDX_W-1:0] match_rank_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [IDX_W-1:0] free_rank_reg;
    logic [IDX_W-1:0] lru_idx_reg;
    logic             cmp_occ;
    logic             hit_now;

    assign cmp_occ = occupied[cmp_idx_reg];
    assign hit_now = cmp_valid_reg && cmp_occ && (tag_rd == key);

    // Compare stage registers the issue so that it lines up with the registered tag read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
        end
        else
        begin
            cmp_valid_reg <= ctl.issue;
            cmp_idx_reg   <= issue_idx;
        end
    end

    // First-find flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            lru_found_reg   <= 1'b0;
        end
        else if (ctl.clear)
        begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            lru_found_reg   <= 1'b0;
        end
        else
        begin
            if (hit_now)
            begin
                match_found_reg <= 1'b1;
            end
            if (cmp_valid_reg && !cmp_occ)
            begin
                free_found_reg <= 1'b1;
            end
            if (cmp_valid_reg && cmp_lru)
            begin
                lru_found_reg <= 1'b1;
            end
        end
    end

    // Captured slot indices and ranks
    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            lru_idx_reg <= '0;
        end
        else
        begin
            if (hit_now && !match_found_reg)
            begin
                match_idx_reg  <= cmp_idx_reg;
                match_rank_reg <= cmp_rank;
            end
            if (cmp_valid_reg && !cmp_occ && !free_found_reg)
            begin
                free_idx_reg  <= cmp_idx_reg;
                free_rank_reg <= cmp_rank;
            end
            if (cmp_valid_reg && cmp_lru && !lru_found_reg)
            begin
                lru_idx_reg <= cmp_idx_reg;
            end
        end
    end

    assign cmp_idx         = cmp_idx_reg;
    assign res.match_found = match_found_reg;
    assign res.free_found  = free_found_reg;
    assign match_idx       = match_idx_reg;
    assign match_rank      = match_rank_reg;
    assign free_idx        = free_idx_reg;
    assign free_rank       = free_rank_reg;
    assign lru_idx         = lru_idx_reg;

endmodule

`default_nettype wire

FILE: rtl/sector_cache_lru_controller.sv
// ============================================================================
// sector_cache_lru_controller
// Tag, LRU and dirty controller of a fully associative write-back sector
// cache with one-sector read-ahead.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready, command, sector) takes read, write and
//   write-back tick transactions. Output channel (out_valid/out_ready) returns
//   one transaction per action: write back, fill or grant; last marks the
//   final one of a request. in_ready is high only while the sequencer idles.
//   Every lookup walks the tag RAM one slot per cycle through its single
//   read port; a hit takes one pass and a miss two, the second for the
//   read-ahead sector, plus a write-back transaction per dirty victim. A
//   tick walks the dirty flags up to the last dirty slot and returns a
//   write-back per dirty slot; with nothing dirty it returns nothing and
//   in_ready stays high. Unknown commands are dropped.
//   Results sit in an output register; a stalled receiver holds the
//   sequencer in its emit state, nothing is lost.
//   Reset clears occupied and dirty flags and sets ranks to slot order
//   (slot 0 most recent); the tag RAM needs no clearing pass.
// ============================================================================
`default_nettype none

module sector_cache_lru_controller #(
    parameter int CACHE_SLOTS = scu_pkg::CACHE_SLOTS_DEF,
    parameter int SECTOR_BITS = scu_pkg::SECTOR_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [scu_pkg::CMD_W-1:0]    command,
    input  wire logic [scu_pkg::SECTOR_W-1:0] sector,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [scu_pkg::ACT_W-1:0]    action,
    output logic      [scu_pkg::SLOT_W-1:0]   slot,
    output logic      [scu_pkg::SECTOR_W-1:0] target_sector,
    output logic                              hit,
    output logic                              last
);

    localparam int IDX_W = $clog2(CACHE_SLOTS);
    localparam int CNT_W = $clog2(CACHE_SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_SLOTS - 1);

    // Sequencer registers
    scu_pkg::state_t          state_reg, state_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [scu_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [SECTOR_BITS-1:0]   key_reg, key_next;
    logic [SECTOR_BITS-1:0]   req_sector_reg, req_sector_next;
    logic [IDX_W-1:0]         req_slot_reg, req_slot_next;
    logic                     hit_reg, hit_next;
    logic                     ahead_reg, ahead_next;
    logic [IDX_W-1:0]         victim_reg, victim_next;
    logic [IDX_W-1:0]         victim_rank_reg, victim_rank_next;
    logic [CACHE_SLOTS-1:0]   occupied_reg, occupied_next;
    logic [CACHE_SLOTS-1:0]   dirty_reg, dirty_next;
    logic [CNT_W-1:0]         dirty_cnt_reg, dirty_cnt_next;

    // Output register
    logic                           out_valid_reg, out_valid_next;
    logic [scu_pkg::ACT_W-1:0]      out_action_reg, out_action_next;
    logic [scu_pkg::SLOT_W-1:0]     out_slot_reg, out_slot_next;
    logic [scu_pkg::SECTOR_W-1:0]   out_sector_reg, out_sector_next;
    logic                           out_hit_reg, out_hit_next;
    logic                           out_last_reg, out_last_next;

    // Submodule connections
    logic                   ram_wr_en;
    logic                   ram_rd_en;
    logic [IDX_W-1:0]       ram_rd_addr;
    logic [SECTOR_BITS-1:0] ram_rd_data;
    scu_pkg::scan_ctl_t     scan_ctl;
    scu_pkg::scan_res_t     scan_res;
    logic [IDX_W-1:0]       cmp_idx;
    logic [IDX_W-1:0]       cmp_rank;
    logic                   cmp_lru;
    logic [IDX_W-1:0]       match_idx;
    logic [IDX_W-1:0]       match_rank;
    logic [IDX_W-1:0]       free_idx;
    logic [IDX_W-1:0]       free_rank;
    logic [IDX_W-1:0]       lru_idx;
    logic                   promote_en;
    logic [IDX_W-1:0]       promote_slot;
    logic [IDX_W-1:0]       promote_old;
    logic                   out_free;
    logic                   in_accept;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == scu_pkg::ST_IDLE);
    assign in_accept = in_valid && in_ready;

    // Tag store
    scu_tag_ram #(
        .DEPTH (CACHE_SLOTS),
        .WIDTH (SECTOR_BITS)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (victim_reg),
        .wr_data (key_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Recency ranks
    scu_recency #(
        .CACHE_SLOTS (CACHE_SLOTS)
    ) u_recency (
        .clk          (clk),
        .rst_n        (rst_n),
        .promote_en   (promote_en),
        .promote_slot (promote_slot),
        .promote_old  (promote_old),
        .rd_idx       (cmp_idx),
        .rd_rank      (cmp_rank),
        .rd_lru       (cmp_lru)
    );

    // Shared scan / compare unit
    scu_scan #(
        .CACHE_SLOTS (CACHE_SLOTS),
        .SECTOR_BITS (SECTOR_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .issue_idx  (idx_reg),
        .key        (key_reg),
        .tag_rd     (ram_rd_data),
        .occupied   (occupied_reg),
        .cmp_rank   (cmp_rank),
        .cmp_lru    (cmp_lru),
        .cmp_idx    (cmp_idx),
        .res        (scan_res),
        .match_idx  (match_idx),
        .match_rank (match_rank),
        .free_idx   (free_idx),
        .free_rank  (free_rank),
        .lru_idx    (lru_idx)
    );

    // Sequencer: next state and outputs
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        req_sector_next  = req_sector_reg;
        req_slot_next    = req_slot_reg;
        hit_next         = hit_reg;
        ahead_next       = ahead_reg;
        victim_next      = victim_reg;
        victim_rank_next = victim_rank_reg;
        occupied_next    = occupied_reg;
        dirty_next       = dirty_reg;
        dirty_cnt_next   = dirty_cnt_reg;

        out_valid_next   = out_valid_reg && !out_ready;
        out_action_next  = out_action_reg;
        out_slot_next    = out_slot_reg;
        out_sector_next  = out_sector_reg;
        out_hit_next     = out_hit_reg;
        out_last_next    = out_last_reg;

        ram_wr_en        = 1'b0;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = idx_reg;
        scan_ctl.clear   = 1'b0;
        scan_ctl.issue   = 1'b0;
        promote_en       = 1'b0;
        promote_slot     = victim_reg;
        promote_old      = victim_rank_reg;

        unique case (state_reg)
            scu_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    cmd_next        = command;
                    key_next        = sector[SECTOR_BITS-1:0];
                    req_sector_next = sector[SECTOR_BITS-1:0];
                    hit_next        = 1'b0;
                    ahead_next      = 1'b0;
                    idx_next        = '0;
                    unique case (command)
                        scu_pkg::CMD_READ, scu_pkg::CMD_WRITE:
                        begin
                            scan_ctl.clear = 1'b1;
                            state_next     = scu_pkg::ST_SCAN;
                        end
                        scu_pkg::CMD_TICK:
                        begin
                            if (dirty_cnt_reg != '0)
                            begin
                                state_next = scu_pkg::ST_TICK_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = scu_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            // Issue one tag read per cycle
            scu_pkg::ST_SCAN:
            begin
                ram_rd_en      = 1'b1;
                scan_ctl.issue = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = scu_pkg::ST_SCAN_END;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            // Last compare lands
            scu_pkg::ST_SCAN_END:
            begin
                state_next = scu_pkg::ST_DECIDE;
            end

            // Hit, free slot or eviction
            scu_pkg::ST_DECIDE:
            begin
                if (scan_res.match_found)
                begin
                    promote_en   = 1'b1;
                    promote_slot = match_idx;
                    promote_old  = match_rank;
                    if (!ahead_reg)
                    begin
                        req_slot_next = match_idx;
                        hit_next      = 1'b1;
                    end
                    state_next = scu_pkg::ST_GRANT;
                end
                else if (scan_res.free_found)
                begin
                    victim_next      = free_idx;
                    victim_rank_next = free_rank;
                    state_next       = scu_pkg::ST_FILL;
                end
                else
                begin
                    victim_next      = lru_idx;
                    victim_rank_next = LAST_IDX;
                    if (dirty_reg[lru_idx])
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = lru_idx;
                        state_next  = scu_pkg::ST_WB_EMIT;
                    end
                    else
                    begin
                        state_next = scu_pkg::ST_FILL;
                    end
                end
            end

            // Write back the evicted dirty slot
            scu_pkg::ST_WB_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_action_next         = scu_pkg::ACT_WRITEBACK;
                    out_slot_next           = scu_pkg::SLOT_W'(victim_reg);
                    out_sector_next         = scu_pkg::SECTOR_W'(ram_rd_data);
                    out_hit_next            = 1'b0;
                    out_last_next           = 1'b0;
                    dirty_next[victim_reg]  = 1'b0;
                    dirty_cnt_next          = dirty_cnt_reg - CNT_W'(1);
                    state_next              = scu_pkg::ST_FILL;
                end
            end

            // Fill the victim slot and make it most recent
            scu_pkg::ST_FILL:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_action_next           = scu_pkg::ACT_FILL;
                    out_slot_next             = scu_pkg::SLOT_W'(victim_reg);
                    out_sector_next           = scu_pkg::SECTOR_W'(key_reg);
                    out_hit_next              = 1'b0;
                    out_last_next             = 1'b0;
                    ram_wr_en                 = 1'b1;
                    occupied_next[victim_reg] = 1'b1;
                    promote_en                = 1'b1;
                    if (!ahead_reg)
                    begin
                        // Requested sector done, look up the read-ahead sector
                        req_slot_next  = victim_reg;
                        key_next       = key_reg + SECTOR_BITS'(1);
                        ahead_next     = 1'b1;
                        idx_next       = '0;
                        scan_ctl.clear = 1'b1;
                        state_next     = scu_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = scu_pkg::ST_GRANT;
                    end
                end
            end

            // Final grant; a write marks the slot dirty
            scu_pkg::ST_GRANT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_action_next = scu_pkg::ACT_GRANT;
                    out_slot_next   = scu_pkg::SLOT_W'(req_slot_reg);
                    out_sector_next = scu_pkg::SECTOR_W'(req_sector_reg);
                    out_hit_next    = hit_reg;
                    out_last_next   = 1'b1;
                    if (cmd_reg == scu_pkg::CMD_WRITE)
                    begin
                        dirty_next[req_slot_reg] = 1'b1;
                        if (!dirty_reg[req_slot_reg])
                        begin
                            dirty_cnt_next = dirty_cnt_reg + CNT_W'(1);
                        end
                    end
                    state_next = scu_pkg::ST_IDLE;
                end
            end

            // Tick: walk dirty flags, read tag of each dirty slot
            scu_pkg::ST_TICK_SCAN:
            begin
                if (dirty_reg[idx_reg])
                begin
                    ram_rd_en  = 1'b1;
                    state_next = scu_pkg::ST_TICK_EMIT;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = scu_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            scu_pkg::ST_TICK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_action_next      = scu_pkg::ACT_WRITEBACK;
                    out_slot_next        = scu_pkg::SLOT_W'(idx_reg);
                    out_sector_next      = scu_pkg::SECTOR_W'(ram_rd_data);
                    out_hit_next         = 1'b0;
                    out_last_next        = (dirty_cnt_reg == CNT_W'(1));
                    dirty_next[idx_reg]  = 1'b0;
                    dirty_cnt_next       = dirty_cnt_reg - CNT_W'(1);
                    if ((dirty_cnt_reg == CNT_W'(1)) || (idx_reg == LAST_IDX))
                    begin
                        state_next = scu_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = scu_pkg::ST_TICK_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = scu_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scu_pkg::ST_IDLE;
            idx_reg       <= '0;
            ahead_reg     <= 1'b0;
            occupied_reg  <= '0;
            dirty_reg     <= '0;
            dirty_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            ahead_reg     <= ahead_next;
            occupied_reg  <= occupied_next;
            dirty_reg     <= dirty_next;
            dirty_cnt_reg <= dirty_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        key_reg         <= key_next;
        req_sector_reg  <= req_sector_next;
        req_slot_reg    <= req_slot_next;
        hit_reg         <= hit_next;
        victim_reg      <= victim_next;
        victim_rank_reg <= victim_rank_next;
        out_action_reg  <= out_action_next;
        out_slot_reg    <= out_slot_next;
        out_sector_reg  <= out_sector_next;
        out_hit_reg     <= out_hit_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign action        = out_action_reg;
    assign slot          = out_slot_reg;
    assign target_sector = out_sector_reg;
    assign hit           = out_hit_reg;
    assign last          = out_last_reg;

endmodule

`default_nettype wire

FILE: rtl/scu_checker.sv
// ============================================================================
// scu_checker
// Port-level checks of the sector cache controller, bound to the top level.
// ============================================================================
`default_nettype none

module scu_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic [scu_pkg::CMD_W-1:0]    command,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic [scu_pkg::ACT_W-1:0]    action,
    input wire logic [scu_pkg::SLOT_W-1:0]   slot,
    input wire logic [scu_pkg::SECTOR_W-1:0] target_sector,
    input wire logic                         hit,
    input wire logic                         last
);

    // Stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(action) && $stable(slot)
            && $stable(target_sector) && $stable(hit) && $stable(last))
    else $error("stalled result changed");

    // A request keeps the block busy after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (command == scu_pkg::CMD_READ || command == scu_pkg::CMD_WRITE)
            |=> !in_ready)
    else $error("request accepted without busy period");

    // Grant always closes a request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == scu_pkg::ACT_GRANT) |-> last)
    else $error("grant not marked last");

    // Fill never closes a request and never reports a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == scu_pkg::ACT_FILL) |-> !last && !hit)
    else $error("fill marked last or hit");

    // Hit only on grants
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> (action == scu_pkg::ACT_GRANT))
    else $error("hit on non-grant result");

endmodule

bind sector_cache_lru_controller scu_checker u_scu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .action        (action),
    .slot          (slot),
    .target_sector (target_sector),
    .hit           (hit),
    .last          (last)
);

`default_nettype wire

FILE: test/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the sector cache tag / LRU / dirty controller.
// A local cache model predicts every write-back, fill and grant for each
// accepted request; the monitor checks each output transaction against the
// oldest prediction. Directed corner cases come first (wrap, read-ahead hit,
// empty tick, unknown command), then random traffic concentrated on a small
// working set so that hits, evictions and dirty write-backs all occur.
// ============================================================================
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CACHE_SLOTS = scu_pkg::CACHE_SLOTS_DEF;
    localparam int RANDOM_REQS = 280;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 2 * CACHE_SLOTS + 40;
    localparam int PRINT_LIMIT = 40;
    localparam logic [scu_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    typedef struct {
        logic [scu_pkg::CMD_W-1:0]    cmd;
        logic [scu_pkg::SECTOR_W-1:0] sec;
    } sector_request_t;

    typedef struct {
        logic [scu_pkg::ACT_W-1:0]    action;
        logic [scu_pkg::SLOT_W-1:0]   slot;
        logic [scu_pkg::SECTOR_W-1:0] target;
        logic                         hit;
        logic                         last;
    } slot_action_t;

    // DUT ports, inputs known from time zero
    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [scu_pkg::CMD_W-1:0]    command = scu_pkg::CMD_READ;
    logic [scu_pkg::SECTOR_W-1:0] sector = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [scu_pkg::ACT_W-1:0]    action;
    logic [scu_pkg::SLOT_W-1:0]   slot;
    logic [scu_pkg::SECTOR_W-1:0] target_sector;
    logic                         hit;
    logic                         last;

    // Bench state
    sector_request_t request_q[$];
    slot_action_t    step_actions[$];
    slot_action_t    expected_actions[$];
    bit              in_took = 1'b0;
    int              idle_cycles = 0;
    int              cycle_count = 0;
    int              mismatch_count = 0;
    int              in_gap = 0;
    int              stall_left = 0;
    logic [scu_pkg::SECTOR_W-1:0] hot_base;

    // Cache model state
    logic [scu_pkg::SECTOR_W-1:0] line_tag   [CACHE_SLOTS];
    bit                           line_valid [CACHE_SLOTS];
    bit                           line_dirty [CACHE_SLOTS];
    int                           line_age   [CACHE_SLOTS];

    sector_cache_lru_controller DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .sector        (sector),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .action        (action),
        .slot          (slot),
        .target_sector (target_sector),
        .hit           (hit),
        .last          (last)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Cache model
    // ------------------------------------------------------------------
    function automatic void add_action(logic [scu_pkg::ACT_W-1:0] act, int s,
                                       logic [scu_pkg::SECTOR_W-1:0] sec, logic h);
        slot_action_t a;
        a.action = act;
        a.slot   = s[scu_pkg::SLOT_W-1:0];
        a.target = sec;
        a.hit    = h;
        a.last   = 1'b0;
        step_actions.push_back(a);
    endfunction

    // make slot s most recent, aging everything younger than it
    function automatic void touch_line(int s);
        int old_age;
        old_age = line_age[s];
        for (int i = 0; i < CACHE_SLOTS; i++)
            if (line_age[i] < old_age)
                line_age[i]++;
        line_age[s] = 0;
    endfunction

    function automatic int find_line(logic [scu_pkg::SECTOR_W-1:0] sec);
        for (int i = 0; i < CACHE_SLOTS; i++)
            if (line_valid[i] && line_tag[i] == sec)
                return i;
        return -1;
    endfunction

    // lowest free slot, else evict the oldest; then fill and make recent
    function automatic int claim_line(logic [scu_pkg::SECTOR_W-1:0] sec);
        int s;
        s = -1;
        for (int i = 0; i < CACHE_SLOTS; i++)
            if (s < 0 && !line_valid[i])
                s = i;
        if (s < 0)
        begin
            s = 0;
            for (int i = CACHE_SLOTS - 1; i >= 0; i--)
                if (line_age[i] == CACHE_SLOTS - 1)
                    s = i;
            if (line_dirty[s])
            begin
                add_action(scu_pkg::ACT_WRITEBACK, s, line_tag[s], 1'b0);
                line_dirty[s] = 1'b0;
            end
            line_valid[s] = 1'b0;
        end
        line_tag[s]   = sec;
        line_valid[s] = 1'b1;
        line_dirty[s] = 1'b0;
        add_action(scu_pkg::ACT_FILL, s, sec, 1'b0);
        touch_line(s);
        return s;
    endfunction

    function automatic void predict_request(logic [scu_pkg::CMD_W-1:0] cmd,
                                            logic [scu_pkg::SECTOR_W-1:0] sec);
        int s;
        int ahead;
        logic [scu_pkg::SECTOR_W-1:0] next_sec;
        slot_action_t tail;
        step_actions.delete();
        if (cmd == scu_pkg::CMD_TICK)
        begin
            for (int i = 0; i < CACHE_SLOTS; i++)
                if (line_dirty[i])
                begin
                    add_action(scu_pkg::ACT_WRITEBACK, i, line_tag[i], 1'b0);
                    line_dirty[i] = 1'b0;
                end
        end
        else if (cmd == scu_pkg::CMD_READ || cmd == scu_pkg::CMD_WRITE)
        begin
            s = find_line(sec);
            if (s >= 0)
            begin
                touch_line(s);
                add_action(scu_pkg::ACT_GRANT, s, sec, 1'b1);
            end
            else
            begin
                next_sec = sec + 1'b1;
                s = claim_line(sec);
                ahead = find_line(next_sec);
                if (ahead >= 0)
                    touch_line(ahead);
                else
                    ahead = claim_line(next_sec);
                add_action(scu_pkg::ACT_GRANT, s, sec, 1'b0);
            end
            if (cmd == scu_pkg::CMD_WRITE)
                line_dirty[s] = 1'b1;
        end
        if (step_actions.size() > 0)
        begin
            tail = step_actions.pop_back();
            tail.last = 1'b1;
            step_actions.push_back(tail);
        end
        foreach (step_actions[i])
            expected_actions.push_back(step_actions[i]);
    endfunction

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [scu_pkg::SECTOR_W-1:0] got,
                                   logic [scu_pkg::SECTOR_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // mostly short gaps, a few long ones; periodic stretches have none
    function automatic int pick_gap();
        int r;
        if ((cycle_count % 4000) < 800)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [scu_pkg::SECTOR_W-1:0] pick_sector();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return hot_base + $urandom_range(0, 95);
        else if (r < 80)
            return '1 - $urandom_range(0, 3);
        else if (r < 85)
            return $urandom_range(0, 3);
        return $urandom();
    endfunction

    function automatic void queue_request(logic [scu_pkg::CMD_W-1:0] cmd,
                                          logic [scu_pkg::SECTOR_W-1:0] sec);
        sector_request_t req;
        req.cmd = cmd;
        req.sec = sec;
        request_q.push_back(req);
    endfunction

    // ------------------------------------------------------------------
    // Request driver: changes on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_requests
        sector_request_t req;
        if (rst_n)
        begin
            if (in_valid && !in_took)
                ; // hold until accepted
            else if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap--;
            end
            else if (request_q.size() > 0)
            begin
                req = request_q.pop_front();
                in_valid <= 1'b1;
                command  <= req.cmd;
                sector   <= req.sec;
                in_gap = pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result backpressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left == 0 && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: samples on the rising edge, predicts and checks
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_ports
        slot_action_t want;
        in_took = in_valid && in_ready;
        if (rst_n)
        begin
            cycle_count++;
            if (in_took || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;

            if (out_valid && out_ready)
            begin
                if (expected_actions.size() == 0)
                    report_mismatch("result transaction with nothing pending, sector",
                                    target_sector, '0);
                else
                begin
                    want = expected_actions.pop_front();
                    if (action !== want.action)
                        report_mismatch("action", action, want.action);
                    if (slot !== want.slot)
                        report_mismatch("slot", slot, want.slot);
                    if (target_sector !== want.target)
                        report_mismatch("target_sector", target_sector, want.target);
                    if (hit !== want.hit)
                        report_mismatch("hit", hit, want.hit);
                    if (last !== want.last)
                        report_mismatch("last", last, want.last);
                end
            end

            if (in_took)
                predict_request(command, sector);
        end
    end

    // Watchdog on transaction activity
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------
    initial
    begin : run_test
        int n_random;
        int r;
        logic [scu_pkg::CMD_W-1:0] cmd;
        slot_action_t leftover;

        // model reset: nothing held, slot 0 most recent
        for (int i = 0; i < CACHE_SLOTS; i++)
        begin
            line_tag[i]   = '0;
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
            line_age[i]   = i;
        end

        // directed corner cases
        queue_request(scu_pkg::CMD_TICK,  32'h0000_0000);  // tick on an empty cache
        queue_request(CMD_UNKNOWN,        32'h1234_5678);  // dropped
        queue_request(scu_pkg::CMD_READ,  32'h0000_0000);
        queue_request(scu_pkg::CMD_READ,  32'h0000_0001);  // hit on read-ahead line
        queue_request(scu_pkg::CMD_WRITE, 32'hFFFF_FFFF);  // wraps, read-ahead hits 0
        queue_request(scu_pkg::CMD_WRITE, 32'h0000_0000);
        queue_request(scu_pkg::CMD_TICK,  32'hFFFF_FFFF);
        queue_request(scu_pkg::CMD_TICK,  32'h0000_0000);  // nothing dirty
        queue_request(scu_pkg::CMD_WRITE, 32'hAAAA_AAAA);
        queue_request(scu_pkg::CMD_WRITE, 32'h5555_5555);
        queue_request(scu_pkg::CMD_READ,  32'hFFFF_FFFE);
        queue_request(scu_pkg::CMD_WRITE, 32'hFFFF_FFFE);
        queue_request(scu_pkg::CMD_READ,  32'h8000_0000);
        queue_request(scu_pkg::CMD_WRITE, 32'h7FFF_FFFF);
        queue_request(scu_pkg::CMD_READ,  32'hAAAA_AAAB);
        queue_request(scu_pkg::CMD_TICK,  32'h5555_5555);
        queue_request(CMD_UNKNOWN,        32'hFFFF_FFFF);

        // random traffic over a working set larger than the cache
        hot_base = $urandom();
        n_random = 0;
        while (n_random < RANDOM_REQS)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                cmd = CMD_UNKNOWN;
            else if (r < 14)
                cmd = scu_pkg::CMD_TICK;
            else if (r < 56)
                cmd = scu_pkg::CMD_READ;
            else
                cmd = scu_pkg::CMD_WRITE;
            queue_request(cmd, pick_sector());
            if (cmd != CMD_UNKNOWN)
                n_random++;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // all requests taken, then all results back, then let it settle
        while (request_q.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_actions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        while (expected_actions.size() != 0)
        begin
            leftover = expected_actions.pop_front();
            report_mismatch("result never delivered, sector", '0, leftover.target);
        end

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
